/* rtl/hpri_pkg.sv */
// Package for the Hall-peak rotary valve indexer.
// Holds the request/response structs, opcodes, register indexes and helper functions.
// No dependencies.
`timescale 1ns / 1ps

package hpri_pkg;

    // Request opcodes
    localparam logic [1:0] OP_START  = 2'd0;
    localparam logic [1:0] OP_SAMPLE = 2'd1;
    localparam logic [1:0] OP_TICK   = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] CFG_IDLE_LEVEL     = 3'd0;
    localparam logic [2:0] CFG_PEAK_THRESHOLD = 3'd1;
    localparam logic [2:0] CFG_PORT_COUNT     = 3'd2;
    localparam logic [2:0] CFG_MICROSTEP      = 3'd3;
    localparam logic [2:0] CFG_TIMEOUT_MS     = 3'd4;
    localparam logic [2:0] CFG_CW_NUMBERING   = 3'd5;
    localparam logic [2:0] CFG_ENABLE_HIGH    = 3'd6;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 12;

    // Full steps in one coarse move
    localparam logic [1:0] COARSE_FULL_STEPS = 2'd3;

    typedef struct packed {
        logic [1:0] opcode;
        logic [3:0] target_port;
        logic [9:0] hall_sample;
    } cmd_t;

    typedef struct packed {
        logic       step_request;
        logic       step_reverse;
        logic [6:0] step_count;
        logic       driver_enable;
        logic       move_done;
        logic       move_status;
        logic [3:0] position_now;
    } rsp_t;

    // Absolute distance of a Hall reading from the idle level
    function automatic logic [9:0] hall_deviation(input logic [9:0] s, input logic [9:0] idle);
        logic [9:0] d;
        begin
            d = (s >= idle) ? (s - idle) : (idle - s);
            return d;
        end
    endfunction

    // Port number modulo port count (2..16), restoring division in four steps
    function automatic logic [4:0] port_mod(input logic [3:0] x, input logic [4:0] p);
        logic [7:0] r;
        logic [7:0] ps;
        begin
            r = {4'd0, x};
            for (int k = 3; k >= 0; k--)
            begin
                ps = {3'd0, p} << k;
                if (r >= ps)
                begin
                    r = r - ps;
                end
            end
            return r[4:0];
        end
    endfunction

endpackage

/* rtl/hall_peak_rotary_indexer.sv */
// Top level of the Hall-peak rotary valve indexer: config registers, move state and
// response register. Depends on hpri_pkg.
`timescale 1ns / 1ps

// Accepts one request (start, Hall sample or millisecond tick) per clock and returns
// exactly one response per request, in the cycle after acceptance, from a response
// register. The request side stalls only while that register holds a response the
// downstream side has not taken, so with no downstream stall the block sustains one
// request per cycle. Configuration registers are written
// through cfg_write/cfg_index/cfg_data and should only be changed between moves.
module hall_peak_rotary_indexer
    import hpri_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // request channel
    input  logic                   cmd_valid,
    output logic                   cmd_stall,
    input  cmd_t                   cmd,
    // response channel
    output logic                   rsp_valid,
    input  logic                   rsp_stall,
    output rsp_t                   rsp,
    // configuration write port
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_COARSE = 2'd1,
        PH_FINE   = 2'd2
    } phase_t;

    // Configuration registers
    logic [9:0]  idle_level_reg;
    logic [9:0]  peak_threshold_reg;
    logic [4:0]  port_count_reg;
    logic [5:0]  microstep_reg;
    logic [11:0] timeout_ms_reg;
    logic        cw_numbering_reg;
    logic        enable_high_reg;

    // Move state
    phase_t      phase_reg, phase_next;
    logic [3:0]  current_port_reg, current_port_next;
    logic [3:0]  goal_port_reg, goal_port_next;
    logic        moving_negative_reg, moving_negative_next;
    logic [3:0]  peaks_needed_reg, peaks_needed_next;
    logic [4:0]  peaks_seen_reg, peaks_seen_next;
    logic        above_flag_reg, above_flag_next;
    logic        small_step_reg, small_step_next;
    logic [9:0]  prev_sample_reg, prev_sample_next;
    logic [11:0] elapsed_ms_reg, elapsed_ms_next;

    // Response register
    logic        rsp_valid_reg, rsp_valid_next;
    rsp_t        rsp_reg, rsp_next;

    logic        cmd_accept;
    logic [4:0]  ports_eff;
    logic [5:0]  micro_eff;
    logic [6:0]  micro_cnt;
    logic [6:0]  coarse_cnt;
    logic [9:0]  dev_now;
    logic [9:0]  dev_prev;
    logic        above_now;
    logic [4:0]  tgt_mod;
    logic [4:0]  cur_mod;
    logic [4:0]  port_gap;
    logic [12:0] elapsed_inc;
    logic        req;
    logic [6:0]  cnt;
    logic        done;
    logic        status;

    // Stall requests only while an untaken response is held
    assign cmd_stall  = rsp_valid_reg & rsp_stall;
    assign cmd_accept = cmd_valid & ~cmd_stall;
    assign rsp_valid  = rsp_valid_reg;
    assign rsp        = rsp_reg;

    // Clamp configuration to usable ranges
    always_comb
    begin
        if (port_count_reg < 5'd2)
        begin
            ports_eff = 5'd2;
        end
        else if (port_count_reg > 5'd16)
        begin
            ports_eff = 5'd16;
        end
        else
        begin
            ports_eff = port_count_reg;
        end

        if (microstep_reg == 6'd0)
        begin
            micro_eff = 6'd1;
        end
        else if (microstep_reg > 6'd32)
        begin
            micro_eff = 6'd32;
        end
        else
        begin
            micro_eff = microstep_reg;
        end
    end

    assign micro_cnt  = {1'b0, micro_eff};
    assign coarse_cnt = 7'(micro_cnt * {5'd0, COARSE_FULL_STEPS});

    assign dev_now     = hall_deviation(cmd.hall_sample, idle_level_reg);
    assign dev_prev    = hall_deviation(prev_sample_reg, idle_level_reg);
    assign above_now   = dev_now >= peak_threshold_reg;
    assign tgt_mod     = port_mod(cmd.target_port, ports_eff);
    assign cur_mod     = port_mod(current_port_reg, ports_eff);
    assign port_gap    = (tgt_mod >= cur_mod) ? (tgt_mod - cur_mod)
                                              : (tgt_mod + ports_eff - cur_mod);
    assign elapsed_inc = {1'b0, elapsed_ms_reg} + 13'd1;

    // Next move state and response for the request at the input
    always_comb
    begin
        phase_next           = phase_reg;
        current_port_next    = current_port_reg;
        goal_port_next       = goal_port_reg;
        moving_negative_next = moving_negative_reg;
        peaks_needed_next    = peaks_needed_reg;
        peaks_seen_next      = peaks_seen_reg;
        above_flag_next      = above_flag_reg;
        small_step_next      = small_step_reg;
        prev_sample_next     = prev_sample_reg;
        elapsed_ms_next      = elapsed_ms_reg;
        req                  = 1'b0;
        cnt                  = 7'd0;
        done                 = 1'b0;
        status               = 1'b0;

        if (cmd_accept)
        begin
            unique case (cmd.opcode)
                OP_START:
                begin
                    // Take the shorter way around
                    if (port_gap < (ports_eff >> 1))
                    begin
                        moving_negative_next = 1'b0;
                        peaks_needed_next    = port_gap[3:0];
                    end
                    else
                    begin
                        moving_negative_next = 1'b1;
                        peaks_needed_next    = 4'(ports_eff - port_gap);
                    end
                    goal_port_next   = cmd.target_port;
                    peaks_seen_next  = 5'd0;
                    above_flag_next  = 1'b0;
                    small_step_next  = 1'b0;
                    prev_sample_next = 10'd0;
                    elapsed_ms_next  = 12'd0;
                    phase_next       = PH_COARSE;
                    req              = 1'b1;
                    cnt              = coarse_cnt;
                end
                OP_SAMPLE:
                begin
                    if (phase_reg == PH_COARSE)
                    begin
                        // Count rising crossings; shrink the move before the last peak
                        if (!above_flag_reg && above_now)
                        begin
                            peaks_seen_next = peaks_seen_reg + 5'd1;
                            above_flag_next = 1'b1;
                        end
                        if (!above_now)
                        begin
                            above_flag_next = 1'b0;
                            if (peaks_seen_next == {1'b0, peaks_needed_reg})
                            begin
                                small_step_next = 1'b1;
                            end
                        end
                        prev_sample_next = cmd.hall_sample;
                        req              = 1'b1;
                        if (peaks_seen_next <= {1'b0, peaks_needed_reg})
                        begin
                            cnt = small_step_next ? micro_cnt : coarse_cnt;
                        end
                        else
                        begin
                            phase_next = PH_FINE;
                            cnt        = micro_cnt;
                        end
                    end
                    else if (phase_reg == PH_FINE)
                    begin
                        // Climb single steps until the deviation falls off the peak
                        above_flag_next = above_now;
                        if (!above_now || dev_prev <= dev_now)
                        begin
                            req = 1'b1;
                            cnt = micro_cnt;
                        end
                        else
                        begin
                            done              = 1'b1;
                            current_port_next = goal_port_reg;
                            phase_next        = PH_IDLE;
                        end
                        prev_sample_next = cmd.hall_sample;
                    end
                end
                OP_TICK:
                begin
                    if (phase_reg != PH_IDLE)
                    begin
                        elapsed_ms_next = elapsed_inc[12] ? 12'hFFF : elapsed_inc[11:0];
                        if (elapsed_inc > {1'b0, timeout_ms_reg})
                        begin
                            done       = 1'b1;
                            status     = 1'b1;
                            phase_next = PH_IDLE;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end

        rsp_next.step_request  = req;
        rsp_next.step_reverse  = req & (moving_negative_next ^ cw_numbering_reg);
        rsp_next.step_count    = cnt;
        rsp_next.driver_enable = (phase_next != PH_IDLE) ? enable_high_reg : ~enable_high_reg;
        rsp_next.move_done     = done;
        rsp_next.move_status   = status;
        rsp_next.position_now  = current_port_next;

        rsp_valid_next = cmd_accept | (rsp_valid_reg & rsp_stall);
    end

    // Hold configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_level_reg     <= 10'd512;
            peak_threshold_reg <= 10'd0;
            port_count_reg     <= 5'd6;
            microstep_reg      <= 6'd1;
            timeout_ms_reg     <= 12'd2000;
            cw_numbering_reg   <= 1'b0;
            enable_high_reg    <= 1'b1;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_IDLE_LEVEL:     idle_level_reg     <= cfg_data[9:0];
                CFG_PEAK_THRESHOLD: peak_threshold_reg <= cfg_data[9:0];
                CFG_PORT_COUNT:     port_count_reg     <= cfg_data[4:0];
                CFG_MICROSTEP:      microstep_reg      <= cfg_data[5:0];
                CFG_TIMEOUT_MS:     timeout_ms_reg     <= cfg_data[11:0];
                CFG_CW_NUMBERING:   cw_numbering_reg   <= cfg_data[0];
                CFG_ENABLE_HIGH:    enable_high_reg    <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    // Advance move state and response valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg           <= PH_IDLE;
            current_port_reg    <= 4'd0;
            goal_port_reg       <= 4'd0;
            moving_negative_reg <= 1'b0;
            peaks_needed_reg    <= 4'd0;
            peaks_seen_reg      <= 5'd0;
            above_flag_reg      <= 1'b0;
            small_step_reg      <= 1'b0;
            prev_sample_reg     <= 10'd0;
            elapsed_ms_reg      <= 12'd0;
            rsp_valid_reg       <= 1'b0;
        end
        else
        begin
            phase_reg           <= phase_next;
            current_port_reg    <= current_port_next;
            goal_port_reg       <= goal_port_next;
            moving_negative_reg <= moving_negative_next;
            peaks_needed_reg    <= peaks_needed_next;
            peaks_seen_reg      <= peaks_seen_next;
            above_flag_reg      <= above_flag_next;
            small_step_reg      <= small_step_next;
            prev_sample_reg     <= prev_sample_next;
            elapsed_ms_reg      <= elapsed_ms_next;
            rsp_valid_reg       <= rsp_valid_next;
        end
    end

    // Load the response payload on each accepted request
    always_ff @(posedge clk)
    begin
        if (cmd_accept)
        begin
            rsp_reg <= rsp_next;
        end
    end

    // Every accepted request produces a response in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n) cmd_accept |=> rsp_valid_reg)
        else $error("accepted request produced no response");

    // A move request always carries a nonzero step count, and only a move request does
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> (rsp_reg.step_request == (rsp_reg.step_count != 7'd0)))
        else $error("step count disagrees with step request");

    // A finishing response never asks for another move
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_reg.move_done) |-> !rsp_reg.step_request)
        else $error("move finished while requesting a step");

    // The coarse phase never runs past the needed peak count
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_COARSE) |-> (peaks_seen_reg <= {1'b0, peaks_needed_reg}))
        else $error("coarse phase counted too many peaks");

endmodule

/* tb/tb_hall_peak_rotary_indexer.sv */
// Testbench for the Hall-peak rotary valve indexer: drives start, sample and tick requests
// and checks every response against a cycle-free predictor of the move state.
// Depends on hpri_pkg and hall_peak_rotary_indexer.
`timescale 1ns / 1ps

module tb_hall_peak_rotary_indexer;
    import hpri_pkg::*;

    typedef enum logic [1:0] {MV_REST, MV_COARSE, MV_FINE} move_phase_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cmd_valid = 1'b0;
    logic                   cmd_stall;
    cmd_t                   cmd = '0;
    logic                   rsp_valid;
    logic                   rsp_stall = 1'b0;
    rsp_t                   rsp;
    logic                   cfg_write = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    // Predictor copy of the register file
    logic [9:0]  cfg_idle;
    logic [9:0]  cfg_thresh;
    logic [4:0]  cfg_ports;
    logic [5:0]  cfg_micro;
    logic [11:0] cfg_timeout;
    logic        cfg_cw;
    logic        cfg_en_high;

    // Predictor copy of the move state
    move_phase_t move_phase;
    logic [3:0]  at_port;
    logic [3:0]  dest_port;
    logic        reverse_way;
    logic [3:0]  peaks_to_pass;
    logic [4:0]  peaks_passed;
    logic        magnet_high;
    logic        short_coarse;
    logic [9:0]  last_hall;
    logic [11:0] ms_count;

    rsp_t indexer_rsp_due[$];
    int   fail_count = 0;
    int   live_items = 0;
    int   send_idle_pct = 0;
    int   stall_pct = 0;
    int   holdoff_ask = 0;
    int   holdoff_left = 0;

    hall_peak_rotary_indexer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Absolute distance of a Hall reading from the configured idle level
    function automatic logic [9:0] hall_distance(input logic [9:0] s);
        return (s >= cfg_idle) ? (s - cfg_idle) : (cfg_idle - s);
    endfunction

    // Work out the response to one request and advance the predicted state
    function automatic rsp_t advance_indexer(input cmd_t c);
        rsp_t       r;
        int         ports;
        int         micro;
        int         port_gap;
        int         next_ms;
        logic [9:0] dev;
        logic       hi;
        r = '0;
        ports = (cfg_ports < 5'd2) ? 2 : ((cfg_ports > 5'd16) ? 16 : int'(cfg_ports));
        micro = (cfg_micro == 6'd0) ? 1 : ((cfg_micro > 6'd32) ? 32 : int'(cfg_micro));
        dev = hall_distance(c.hall_sample);
        case (c.opcode)
            OP_START:
            begin
                // pick the shorter way around and the peaks to pass on it
                port_gap = (int'(c.target_port) + 16 * ports - int'(at_port)) % ports;
                if (port_gap < ports / 2)
                begin
                    reverse_way = 1'b0;
                    peaks_to_pass = 4'(port_gap);
                end
                else
                begin
                    reverse_way = 1'b1;
                    peaks_to_pass = 4'(ports - port_gap);
                end
                dest_port = c.target_port;
                peaks_passed = '0;
                magnet_high = 1'b0;
                short_coarse = 1'b0;
                last_hall = '0;
                ms_count = '0;
                move_phase = MV_COARSE;
                r.step_request = 1'b1;
                r.step_count = 7'(int'(COARSE_FULL_STEPS) * micro);
            end
            OP_SAMPLE:
            begin
                if (move_phase == MV_COARSE)
                begin
                    // count rising crossings, shrink the move on the falling edge before
                    // the last peak
                    if (!magnet_high && dev >= cfg_thresh)
                    begin
                        peaks_passed = peaks_passed + 5'd1;
                        magnet_high = 1'b1;
                    end
                    if (dev < cfg_thresh)
                    begin
                        magnet_high = 1'b0;
                        if (peaks_passed == {1'b0, peaks_to_pass})
                        begin
                            short_coarse = 1'b1;
                        end
                    end
                    last_hall = c.hall_sample;
                    r.step_request = 1'b1;
                    if (peaks_passed <= {1'b0, peaks_to_pass})
                    begin
                        r.step_count = short_coarse ? 7'(micro)
                                                    : 7'(int'(COARSE_FULL_STEPS) * micro);
                    end
                    else
                    begin
                        move_phase = MV_FINE;
                        r.step_count = 7'(micro);
                    end
                end
                else if (move_phase == MV_FINE)
                begin
                    // climb single steps until the deviation falls off the crest
                    hi = (dev >= cfg_thresh);
                    magnet_high = hi;
                    if (!hi || hall_distance(last_hall) <= dev)
                    begin
                        r.step_request = 1'b1;
                        r.step_count = 7'(micro);
                    end
                    else
                    begin
                        r.move_done = 1'b1;
                        at_port = dest_port;
                        move_phase = MV_REST;
                    end
                    last_hall = c.hall_sample;
                end
            end
            OP_TICK:
            begin
                if (move_phase != MV_REST)
                begin
                    next_ms = int'(ms_count) + 1;
                    ms_count = (next_ms > 4095) ? 12'hFFF : 12'(next_ms);
                    if (next_ms > int'(cfg_timeout))
                    begin
                        r.move_done = 1'b1;
                        r.move_status = 1'b1;
                        move_phase = MV_REST;
                    end
                end
            end
            default:
            begin
            end
        endcase
        if (r.step_request)
        begin
            r.step_reverse = reverse_way ^ cfg_cw;
        end
        r.driver_enable = (move_phase != MV_REST) ? cfg_en_high : ~cfg_en_high;
        r.position_now = at_port;
        return r;
    endfunction

    function automatic string rsp_text(input rsp_t r);
        return $sformatf("req=%0d rev=%0d cnt=%0d en=%0d done=%0d status=%0d pos=%0d",
                         r.step_request, r.step_reverse, r.step_count, r.driver_enable,
                         r.move_done, r.move_status, r.position_now);
    endfunction

    function automatic void note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10)
        begin
            $display("%0t: %s", $realtime, msg);
        end
    endfunction

    task automatic set_idling(input int sender_pct, input int receiver_pct);
        send_idle_pct = sender_pct;
        stall_pct = receiver_pct;
    endtask

    // Offer one request, hold it until taken, then queue its predicted response
    task automatic send_request(input cmd_t c);
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(0, 99) < send_idle_pct)
            begin
                @(posedge clk);
            end
        end
        cmd_valid <= 1'b1;
        cmd <= c;
        @(posedge clk);
        while (cmd_stall)
        begin
            @(posedge clk);
        end
        if (c.opcode == OP_START ||
            ((c.opcode == OP_SAMPLE || c.opcode == OP_TICK) && move_phase != MV_REST))
        begin
            live_items++;
        end
        indexer_rsp_due.push_back(advance_indexer(c));
    endtask

    task automatic send_op(input logic [1:0] op, input logic [3:0] port, input logic [9:0] hall);
        cmd_t c;
        c.opcode = op;
        c.target_port = port;
        c.hall_sample = hall;
        send_request(c);
    endtask

    // Stop offering and wait until every queued response has come back
    task automatic wait_all_responses();
        cmd_valid <= 1'b0;
        while (indexer_rsp_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= 12'(value);
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
        case (idx)
            CFG_IDLE_LEVEL:     cfg_idle = 10'(value);
            CFG_PEAK_THRESHOLD: cfg_thresh = 10'(value);
            CFG_PORT_COUNT:     cfg_ports = 5'(value);
            CFG_MICROSTEP:      cfg_micro = 6'(value);
            CFG_TIMEOUT_MS:     cfg_timeout = 12'(value);
            CFG_CW_NUMBERING:   cfg_cw = 1'(value);
            CFG_ENABLE_HIGH:    cfg_en_high = 1'(value);
            default:
            begin
            end
        endcase
    endtask

    task automatic apply_config(input int idle, input int thresh, input int ports,
                                input int micro, input int tmo, input int cw, input int en);
        wait_all_responses();
        write_reg(CFG_IDLE_LEVEL, idle);
        write_reg(CFG_PEAK_THRESHOLD, thresh);
        write_reg(CFG_PORT_COUNT, ports);
        write_reg(CFG_MICROSTEP, micro);
        write_reg(CFG_TIMEOUT_MS, tmo);
        write_reg(CFG_CW_NUMBERING, cw);
        write_reg(CFG_ENABLE_HIGH, en);
    endtask

    // Mostly whole moves over a simulated rotor with random magnets, some noise requests
    task automatic run_random_moves(input int n_live);
        int          goal_count;
        int          guard;
        int          span;
        int          pos;
        int          k;
        int          dev;
        int          crest;
        int          up;
        int          dn;
        logic [15:0] raw;
        cmd_t        c;
        goal_count = live_items + n_live;
        while (live_items < goal_count)
        begin
            raw = 16'($urandom);
            c = raw;
            if ($urandom_range(0, 99) < 15)
            begin
                send_request(c);
            end
            else
            begin
                c.opcode = OP_START;
                send_request(c);
                span = $urandom_range(3, 6);
                crest = $urandom_range(1, 300);
                pos = 0;
                guard = 0;
                while (move_phase != MV_REST && guard < 60)
                begin
                    raw = 16'($urandom);
                    c = raw;
                    if ($urandom_range(0, 99) < 12)
                    begin
                        c.opcode = OP_TICK;
                    end
                    else
                    begin
                        // two quiet samples, then a triangular magnet passage
                        if (pos < 2)
                        begin
                            dev = (cfg_thresh == 0) ? 0 : $urandom_range(0, cfg_thresh - 1);
                        end
                        else
                        begin
                            k = pos - 2;
                            dev = int'(cfg_thresh) + crest * ((k + 1 < span - k) ? k + 1
                                                                                : span - k) / span;
                        end
                        up = int'(cfg_idle) + dev;
                        dn = int'(cfg_idle) - dev;
                        c.opcode = OP_SAMPLE;
                        if (dn < 0 || (up <= 1023 && $urandom_range(0, 1) == 1))
                        begin
                            c.hall_sample = (up > 1023) ? 10'd1023 : 10'(up);
                        end
                        else
                        begin
                            c.hall_sample = 10'(dn);
                        end
                        pos = (pos + 1) % (span + 2);
                    end
                    send_request(c);
                    guard++;
                end
            end
        end
    endtask

    // Reset values: idle requests ignored, unknown opcode, restart during a move
    task automatic test_reset_defaults();
        send_op(OP_SAMPLE, 4'd0, 10'd700);
        send_op(OP_TICK, 4'd0, 10'd0);
        send_op(2'd3, 4'hF, 10'h3FF);
        send_op(OP_START, 4'd3, 10'd0);
        send_op(OP_SAMPLE, 4'd0, 10'd512);
        send_op(OP_TICK, 4'd0, 10'd0);
        send_op(OP_START, 4'd0, 10'd0);
        send_op(OP_SAMPLE, 4'd0, 10'd0);
    endtask

    // Register extremes, clamped port count and microstep factor, target beyond ports
    task automatic test_config_extremes();
        apply_config(1023, 1023, 0, 0, 1, 1, 0);
        send_op(OP_START, 4'd15, 10'd0);
        send_op(OP_SAMPLE, 4'd0, 10'd0);
        send_op(OP_SAMPLE, 4'd0, 10'd1023);
        send_op(OP_TICK, 4'd0, 10'd0);
        send_op(OP_TICK, 4'd0, 10'd0);
        apply_config(0, 0, 1, 63, 4095, 0, 1);
        send_op(OP_START, at_port, 10'd0);
        send_op(OP_SAMPLE, 4'd0, 10'd1023);
        send_op(OP_SAMPLE, 4'd0, 10'd1023);
        send_op(OP_SAMPLE, 4'd0, 10'd0);
    endtask

    // One clean move across one magnet into the fine search, both field polarities
    task automatic test_full_move();
        apply_config(512, 100, 17, 2, 2000, 0, 1);
        send_op(OP_START, at_port + 4'd1, 10'd0);
        send_op(OP_SAMPLE, 4'd0, 10'd520);
        send_op(OP_SAMPLE, 4'd0, 10'd300);
        send_op(OP_SAMPLE, 4'd0, 10'd600);
        send_op(OP_SAMPLE, 4'd0, 10'd520);
        send_op(OP_SAMPLE, 4'd0, 10'd650);
        send_op(OP_SAMPLE, 4'd0, 10'd700);
        send_op(OP_SAMPLE, 4'd0, 10'd620);
    endtask

    // Timeout on the tick that passes the limit in the coarse phase, and in the fine search
    task automatic test_timeouts();
        set_idling(0, 0);
        apply_config(512, 50, 16, 1, 40, 1, 1);
        send_op(OP_START, at_port, 10'd0);
        repeat (41) send_op(OP_TICK, 4'd0, 10'd0);
        wait_all_responses();
        write_reg(CFG_TIMEOUT_MS, 2);
        send_op(OP_START, at_port, 10'd0);
        send_op(OP_SAMPLE, 4'd0, 10'd700);
        repeat (3) send_op(OP_TICK, 4'd0, 10'd0);
    endtask

    // Hold the response side off while requests keep coming, so the input stalls
    task automatic test_back_pressure();
        apply_config(512, 100, 8, 4, 50, 0, 1);
        set_idling(0, 0);
        holdoff_ask = 80;
        run_random_moves(30);
        wait_all_responses();
    endtask

    task automatic test_random_traffic();
        set_idling(0, 0);
        apply_config(512, 100, 6, 1, 2000, 0, 1);
        run_random_moves(150);
        set_idling(64, 0);
        apply_config(1023, 200, 16, 32, 40, 1, 0);
        run_random_moves(150);
        set_idling(0, 64);
        apply_config(0, 1023, 2, 33, 4095, 0, 1);
        run_random_moves(150);
        set_idling(13, 13);
        apply_config(300, 0, 31, 0, 5, 1, 1);
        run_random_moves(150);
    endtask

    // Drive the response stall: random stalls, or a counted hold-off when asked
    always @(posedge clk)
    begin
        if (holdoff_ask > 0)
        begin
            holdoff_left = holdoff_ask;
            holdoff_ask = 0;
        end
        if (holdoff_left > 0)
        begin
            rsp_stall <= 1'b1;
            holdoff_left--;
        end
        else
        begin
            rsp_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // Check each accepted response against the oldest prediction
    always @(posedge clk)
    begin : check_rsp
        rsp_t  want;
        string bad;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (indexer_rsp_due.size() == 0)
            begin
                note_failure($sformatf("unexpected response: %s", rsp_text(rsp)));
            end
            else
            begin
                want = indexer_rsp_due.pop_front();
                bad = "";
                if (rsp.step_request !== want.step_request) bad = {bad, " step_request"};
                if (rsp.step_reverse !== want.step_reverse) bad = {bad, " step_reverse"};
                if (rsp.step_count !== want.step_count) bad = {bad, " step_count"};
                if (rsp.driver_enable !== want.driver_enable) bad = {bad, " driver_enable"};
                if (rsp.move_done !== want.move_done) bad = {bad, " move_done"};
                if (rsp.move_status !== want.move_status) bad = {bad, " move_status"};
                if (rsp.position_now !== want.position_now) bad = {bad, " position_now"};
                if (bad != "")
                begin
                    note_failure($sformatf("mismatch in%s: expected %s, got %s",
                                           bad, rsp_text(want), rsp_text(rsp)));
                end
            end
        end
    end

    initial
    begin
        cfg_idle = 10'd512;
        cfg_thresh = 10'd0;
        cfg_ports = 5'd6;
        cfg_micro = 6'd1;
        cfg_timeout = 12'd2000;
        cfg_cw = 1'b0;
        cfg_en_high = 1'b1;
        move_phase = MV_REST;
        at_port = '0;
        dest_port = '0;
        reverse_way = 1'b0;
        peaks_to_pass = '0;
        peaks_passed = '0;
        magnet_high = 1'b0;
        short_coarse = 1'b0;
        last_hall = '0;
        ms_count = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_config_extremes();
        test_full_move();
        test_timeouts();
        test_back_pressure();
        test_random_traffic();
        wait_all_responses();
        if (fail_count == 0 && indexer_rsp_due.size() == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Hard limit on run time
    initial
    begin
        #5000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

/* files.f */
rtl/hpri_pkg.sv
rtl/hall_peak_rotary_indexer.sv
tb/tb_hall_peak_rotary_indexer.sv
